FILE: hw/rtl/gfe_pkg.sv
// Package for the gain fade envelope: widths, constants, codes and the
// request structs passed to the bit-serial multiply and divide units.
// No dependencies; every other file in hw/rtl uses it by scoped names.
package gfe_pkg;

  // Field and datapath widths.
  localparam int unsigned LevelW   = 7;   // integer volume
  localparam int unsigned QW       = 15;  // unsigned Q7.8 level
  localparam int unsigned TimeW    = 32;  // millisecond time
  localparam int unsigned LenW     = 16;  // fade duration
  localparam int unsigned FracW    = 16;  // Q0.16 fraction
  localparam int unsigned OpW      = 17;  // serial unit operand width
  localparam int unsigned ProdW    = 2 * OpW;
  localparam int unsigned ScaleW   = 7;   // volume scale percent
  localparam int unsigned StepW    = 5;   // serial step counter
  localparam int unsigned ExpKW    = 28;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Volume scale limits and the divisor for percent scaling.
  localparam logic [ScaleW-1:0] ScaleMax     = 7'd100;
  localparam logic [ScaleW-1:0] ScaleReset   = 7'd100;
  localparam logic [OpW-1:0]    ScaleDivisor = 17'd100;

  // One in Q0.16.
  localparam logic [OpW-1:0] FracOne = 17'h10000;

  // Exponential curve: 0.04 in Q0.32, and the smallest p whose quotient stays at or below one.
  localparam logic [ExpKW-1:0] ExpK    = 28'd171798692;
  localparam logic [OpW-1:0]   ExpMinP = 17'd2622;

  // Step counts of the serial units.
  localparam logic [StepW-1:0] MulSteps   = 5'd17;
  localparam logic [StepW-1:0] FracSteps  = 5'd16;
  localparam logic [StepW-1:0] ExpSteps   = 5'd17;
  localparam logic [StepW-1:0] ScaleSteps = 5'd15;

  // Register index of the volume scale.
  localparam logic [0:0] RegVolumeScale = 1'b0;

  typedef enum logic [1:0] {
    OpTick      = 2'd0,
    OpStartFade = 2'd1,
    OpSetLevel  = 2'd2,
    OpNop       = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CurveLinear     = 2'd0,
    CurveEqualPower = 2'd1,
    CurveExp        = 2'd2,
    CurveNone       = 2'd3
  } curve_e;

  typedef enum logic [2:0] {
    StIdle,
    StFracDiv,
    StShapeMul,
    StShapeDiv,
    StLevelMul,
    StScaleMul,
    StScaleDiv,
    StResult
  } state_e;

  // Multiply request: both operands are latched at start.
  typedef struct packed {
    logic [OpW-1:0] a;
    logic [OpW-1:0] b;
  } mul_req_t;

  // Divide request: the initial partial remainder (below the divisor), the
  // remaining dividend bits left-aligned, the divisor and the step count.
  typedef struct packed {
    logic [OpW-1:0]   rem;
    logic [OpW-1:0]   dividend;
    logic [OpW-1:0]   divisor;
    logic [StepW-1:0] steps;
  } div_req_t;

endpackage

FILE: hw/rtl/gfe_serial_mul.sv
// Bit-serial shift-add multiplier of the gain fade envelope, one multiplier
// bit per cycle, LSB first. Depends on gfe_pkg.
module gfe_serial_mul (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  gfe_pkg::mul_req_t       req_i,
  output logic                    done_o,
  output logic [gfe_pkg::ProdW-1:0] prod_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [gfe_pkg::StepW-1:0]   cnt_q, cnt_d;
  logic [gfe_pkg::OpW-1:0]     a_q, a_d;
  logic [gfe_pkg::OpW:0]       hi_q, hi_d;
  logic [gfe_pkg::OpW-1:0]     lo_q, lo_d;
  logic [gfe_pkg::OpW:0]       sum;
  logic                        last_step;

  // Add the multiplicand when the current multiplier bit is set.
  assign sum       = hi_q + (lo_q[0] ? {1'b0, a_q} : '0);
  assign last_step = (cnt_q == gfe_pkg::MulSteps - 5'd1);

  // Load on start, else shift the partial product right by one bit.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = req_i.a;
      hi_d   = '0;
      lo_d   = req_i.b;
    end else if (busy_q) begin
      hi_d  = {1'b0, sum[gfe_pkg::OpW:1]};
      lo_d  = {sum[0], lo_q[gfe_pkg::OpW-1:1]};
      cnt_d = cnt_q + 5'd1;
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and product shift registers.
  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[gfe_pkg::OpW-1:0], lo_q};

endmodule

FILE: hw/rtl/gfe_serial_div.sv
// Restoring bit-serial divider of the gain fade envelope, one quotient bit
// per cycle, dividend bits shifted in MSB first. Depends on gfe_pkg.
module gfe_serial_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  gfe_pkg::div_req_t         req_i,
  output logic                      done_o,
  output logic [gfe_pkg::OpW-1:0]   quo_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [gfe_pkg::StepW-1:0]   cnt_q, cnt_d;
  logic [gfe_pkg::StepW-1:0]   steps_q, steps_d;
  logic [gfe_pkg::OpW-1:0]     rem_q, rem_d;
  logic [gfe_pkg::OpW-1:0]     dvd_q, dvd_d;
  logic [gfe_pkg::OpW-1:0]     dvs_q, dvs_d;
  logic [gfe_pkg::OpW-1:0]     quo_q, quo_d;
  logic [gfe_pkg::OpW:0]       trial;
  logic                        fits;
  logic                        last_step;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial     = {rem_q, dvd_q[gfe_pkg::OpW-1]};
  assign fits      = trial >= {1'b0, dvs_q};
  assign last_step = (cnt_q == steps_q - 5'd1);

  // Load on start, else produce one quotient bit.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    steps_d = steps_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      steps_d = req_i.steps;
      rem_d   = req_i.rem;
      dvd_d   = req_i.dividend;
      dvs_d   = req_i.divisor;
      quo_d   = '0;
    end else if (busy_q) begin
      rem_d = fits ? gfe_pkg::OpW'(trial - {1'b0, dvs_q}) : trial[gfe_pkg::OpW-1:0];
      dvd_d = {dvd_q[gfe_pkg::OpW-2:0], 1'b0};
      quo_d = {quo_q[gfe_pkg::OpW-2:0], fits};
      cnt_d = cnt_q + 5'd1;
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      steps_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      steps_q <= steps_d;
    end
  end

  // Remainder, dividend and quotient shift registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hw/rtl/gain_fade_envelope.sv
// Top level of the gain fade envelope: request handshakes, fade state,
// sequencer and configuration port. Depends on gfe_pkg, gfe_serial_mul, gfe_serial_div.
//
// Usage: each request on the input channel (in_valid_i / in_ready_o) carries an
// opcode: tick, start fade or set level. Every request gives exactly one result
// on the output channel (out_valid_o / out_ready_i) with level_valid, the
// current Q7.8 output level, fade_active and fade_done.
// Steps: start fade, no-op and idle ticks go straight to the result. A mid-fade
// tick that applies no level runs only the 16-step fraction divide. Set level and
// a completing tick run one 17-step serial multiply and a 15-step serial divide by
// 100. A mid-fade tick with a shaped curve runs a 16-step fraction divide, a
// 17-step shaping multiply or divide, a 17-step level multiply, then the scaling; a
// linear fade skips the shaping step. The serial units are the rate limit; one
// request is in flight at a time and the next is taken once the block returns to
// idle.
// A finished result waits in an output register; the next request is accepted
// while it waits, and a new result stalls only until that register is free.
// Reset clears the fade state, sets the volume scale to 100 and empties the
// output register. The volume scale is written over the APB port, clamped to 100.
module gain_fade_envelope (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     opcode_i,
  input  logic [gfe_pkg::TimeW-1:0]      now_ms_i,
  input  logic [gfe_pkg::LevelW-1:0]     target_level_i,
  input  logic [gfe_pkg::LenW-1:0]       fade_ms_i,
  input  logic [1:0]                     curve_i,
  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           level_valid_o,
  output logic [gfe_pkg::QW-1:0]         out_level_o,
  output logic                           fade_active_o,
  output logic                           fade_done_o,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gfe_pkg::ApbAddrW-1:0]   paddr,
  input  logic [gfe_pkg::ApbDataW-1:0]   pwdata,
  output logic [gfe_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);

  gfe_pkg::state_e                 state_q, state_d;
  logic [gfe_pkg::ScaleW-1:0]      scale_q, scale_d;
  logic [gfe_pkg::QW-1:0]          last_out_q, last_out_d;
  logic [gfe_pkg::QW-1:0]          from_q, from_d;
  logic [gfe_pkg::LevelW-1:0]      target_q, target_d;
  logic [gfe_pkg::TimeW-1:0]       start_q, start_d;
  logic [gfe_pkg::LenW-1:0]        len_q, len_d;
  gfe_pkg::curve_e                 shape_q, shape_d;
  logic                            running_q, running_d;
  logic                            rising_q, rising_d;
  logic [gfe_pkg::QW-1:0]          low_q, low_d;
  logic [gfe_pkg::QW-1:0]          range_q, range_d;
  logic                            valid_q, valid_d;
  logic                            done_q, done_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_lvl_valid_q, out_lvl_valid_d;
  logic [gfe_pkg::QW-1:0]          out_level_q, out_level_d;
  logic                            out_active_q, out_active_d;
  logic                            out_done_q, out_done_d;

  logic                            cfg_write;
  logic [gfe_pkg::ScaleW-1:0]      wr_scale;
  logic [gfe_pkg::TimeW-1:0]       elapsed;
  logic [gfe_pkg::QW-1:0]          tgt_q78;
  logic                            rising_now;
  logic [gfe_pkg::OpW-1:0]         p_val;
  logic [gfe_pkg::OpW-1:0]         v_sq;
  logic [gfe_pkg::QW-1:0]          lvl_sum;

  logic                            mul_start;
  gfe_pkg::mul_req_t               mul_req;
  logic                            mul_done;
  logic [gfe_pkg::ProdW-1:0]       mul_prod;
  logic                            div_start;
  gfe_pkg::div_req_t               div_req;
  logic                            div_done;
  logic [gfe_pkg::OpW-1:0]         div_quo;

  // Serial arithmetic units shared by every step of the sequence.
  gfe_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .req_i   (mul_req),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  gfe_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Configuration port: writes clamp the scale to 100 percent.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == gfe_pkg::RegVolumeScale);
  assign wr_scale  = pwdata[gfe_pkg::ScaleW-1:0];
  assign scale_d   = cfg_write ? ((wr_scale > gfe_pkg::ScaleMax) ? gfe_pkg::ScaleMax : wr_scale)
                               : scale_q;
  assign prdata    = (paddr[2] == gfe_pkg::RegVolumeScale)
                   ? {{(gfe_pkg::ApbDataW - gfe_pkg::ScaleW){1'b0}}, scale_q} : '0;

  // Fade geometry and shaping terms.
  assign elapsed    = now_ms_i - start_q;
  assign tgt_q78    = {target_q, 8'h00};
  assign rising_now = tgt_q78 >= from_q;
  assign p_val      = rising_q ? (gfe_pkg::FracOne - {1'b0, div_quo[gfe_pkg::FracW-1:0]})
                               : {1'b0, div_quo[gfe_pkg::FracW-1:0]};
  assign v_sq       = gfe_pkg::FracOne - mul_prod[2*gfe_pkg::FracW:gfe_pkg::FracW];
  assign lvl_sum    = low_q + mul_prod[gfe_pkg::FracW+gfe_pkg::QW-1:gfe_pkg::FracW];

  assign in_ready_o = (state_q == gfe_pkg::StIdle);

  // Sequencer: next state, unit requests and state updates.
  always_comb begin
    state_d         = state_q;
    last_out_d      = last_out_q;
    from_d          = from_q;
    target_d        = target_q;
    start_d         = start_q;
    len_d           = len_q;
    shape_d         = shape_q;
    running_d       = running_q;
    rising_d        = rising_q;
    low_d           = low_q;
    range_d         = range_q;
    valid_d         = valid_q;
    done_d          = done_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    out_lvl_valid_d = out_lvl_valid_q;
    out_level_d     = out_level_q;
    out_active_d    = out_active_q;
    out_done_d      = out_done_q;
    mul_start       = 1'b0;
    mul_req         = '0;
    div_start       = 1'b0;
    div_req         = '0;

    case (state_q)
      gfe_pkg::StIdle: begin
        if (in_valid_i) begin
          valid_d = 1'b0;
          done_d  = 1'b0;
          state_d = gfe_pkg::StResult;
          case (gfe_pkg::opcode_e'(opcode_i))
            gfe_pkg::OpSetLevel: begin
              // Immediate level cancels any fade.
              running_d = 1'b0;
              shape_d   = gfe_pkg::CurveNone;
              start_d   = '0;
              valid_d   = 1'b1;
              mul_start = 1'b1;
              mul_req.a = {2'b00, target_level_i, 8'h00};
              mul_req.b = {{(gfe_pkg::OpW - gfe_pkg::ScaleW){1'b0}}, scale_q};
              state_d   = gfe_pkg::StScaleMul;
            end
            gfe_pkg::OpStartFade: begin
              start_d   = now_ms_i;
              shape_d   = gfe_pkg::curve_e'(curve_i);
              len_d     = fade_ms_i;
              from_d    = last_out_q;
              target_d  = target_level_i;
              running_d = 1'b1;
            end
            gfe_pkg::OpTick: begin
              if (running_q) begin
                if ((len_q == '0) || (elapsed >= {16'h0000, len_q})) begin
                  // Fade complete: apply the target.
                  running_d = 1'b0;
                  shape_d   = gfe_pkg::CurveNone;
                  start_d   = '0;
                  valid_d   = 1'b1;
                  done_d    = 1'b1;
                  mul_start = 1'b1;
                  mul_req.a = {2'b00, tgt_q78};
                  mul_req.b = {{(gfe_pkg::OpW - gfe_pkg::ScaleW){1'b0}}, scale_q};
                  state_d   = gfe_pkg::StScaleMul;
                end else begin
                  // Mid fade: fraction = elapsed * 2^16 / length.
                  rising_d          = rising_now;
                  low_d             = rising_now ? from_q : tgt_q78;
                  range_d           = rising_now ? (tgt_q78 - from_q) : (from_q - tgt_q78);
                  div_start         = 1'b1;
                  div_req.rem       = {1'b0, elapsed[gfe_pkg::LenW-1:0]};
                  div_req.dividend  = '0;
                  div_req.divisor   = {1'b0, len_q};
                  div_req.steps     = gfe_pkg::FracSteps;
                  state_d           = gfe_pkg::StFracDiv;
                end
              end
            end
            default: begin
              // No operation.
            end
          endcase
        end
      end

      gfe_pkg::StFracDiv: begin
        if (div_done) begin
          case (shape_q)
            gfe_pkg::CurveLinear: begin
              mul_start = 1'b1;
              mul_req.a = {2'b00, range_q};
              mul_req.b = gfe_pkg::FracOne - p_val;
              state_d   = gfe_pkg::StLevelMul;
            end
            gfe_pkg::CurveEqualPower: begin
              mul_start = 1'b1;
              mul_req.a = p_val;
              mul_req.b = p_val;
              state_d   = gfe_pkg::StShapeMul;
            end
            gfe_pkg::CurveExp: begin
              // Only a quotient at or below one is applied.
              if (p_val >= gfe_pkg::ExpMinP) begin
                div_start        = 1'b1;
                div_req.rem      = {{(2 * gfe_pkg::OpW - gfe_pkg::ExpKW){1'b0}},
                                    gfe_pkg::ExpK[gfe_pkg::ExpKW-1:gfe_pkg::OpW]};
                div_req.dividend = gfe_pkg::ExpK[gfe_pkg::OpW-1:0];
                div_req.divisor  = p_val;
                div_req.steps    = gfe_pkg::ExpSteps;
                state_d          = gfe_pkg::StShapeDiv;
              end else begin
                state_d = gfe_pkg::StResult;
              end
            end
            default: begin
              state_d = gfe_pkg::StResult;
            end
          endcase
        end
      end

      gfe_pkg::StShapeMul: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_req.a = {2'b00, range_q};
          mul_req.b = v_sq;
          state_d   = gfe_pkg::StLevelMul;
        end
      end

      gfe_pkg::StShapeDiv: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_req.a = {2'b00, range_q};
          mul_req.b = div_quo;
          state_d   = gfe_pkg::StLevelMul;
        end
      end

      gfe_pkg::StLevelMul: begin
        if (mul_done) begin
          valid_d   = 1'b1;
          mul_start = 1'b1;
          mul_req.a = {2'b00, lvl_sum};
          mul_req.b = {{(gfe_pkg::OpW - gfe_pkg::ScaleW){1'b0}}, scale_q};
          state_d   = gfe_pkg::StScaleMul;
        end
      end

      gfe_pkg::StScaleMul: begin
        // Product is below 100 * 2^15, so the top bits start below the divisor.
        if (mul_done) begin
          div_start        = 1'b1;
          div_req.rem      = {10'h000, mul_prod[21:15]};
          div_req.dividend = {mul_prod[14:0], 2'b00};
          div_req.divisor  = gfe_pkg::ScaleDivisor;
          div_req.steps    = gfe_pkg::ScaleSteps;
          state_d          = gfe_pkg::StScaleDiv;
        end
      end

      gfe_pkg::StScaleDiv: begin
        if (div_done) begin
          last_out_d = div_quo[gfe_pkg::QW-1:0];
          state_d    = gfe_pkg::StResult;
        end
      end

      gfe_pkg::StResult: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d     = 1'b1;
          out_lvl_valid_d = valid_q;
          out_level_d     = last_out_q;
          out_active_d    = running_q;
          out_done_d      = done_q;
          state_d         = gfe_pkg::StIdle;
        end
      end

      default: begin
        state_d = gfe_pkg::StIdle;
      end
    endcase
  end

  // Control and fade state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gfe_pkg::StIdle;
      scale_q     <= gfe_pkg::ScaleReset;
      last_out_q  <= '0;
      from_q      <= '0;
      target_q    <= '0;
      start_q     <= '0;
      len_q       <= '0;
      shape_q     <= gfe_pkg::CurveNone;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scale_q     <= scale_d;
      last_out_q  <= last_out_d;
      from_q      <= from_d;
      target_q    <= target_d;
      start_q     <= start_d;
      len_q       <= len_d;
      shape_q     <= shape_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    rising_q        <= rising_d;
    low_q           <= low_d;
    range_q         <= range_d;
    valid_q         <= valid_d;
    done_q          <= done_d;
    out_lvl_valid_q <= out_lvl_valid_d;
    out_level_q     <= out_level_d;
    out_active_q    <= out_active_d;
    out_done_q      <= out_done_d;
  end

  assign out_valid_o   = out_valid_q;
  assign level_valid_o = out_lvl_valid_q;
  assign out_level_o   = out_level_q;
  assign fade_active_o = out_active_q;
  assign fade_done_o   = out_done_q;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for gain_fade_envelope: drives tick, start-fade, set-level
// and no-op requests and volume scale writes, predicts every result in a scoreboard
// class and checks it. Depends on gfe_pkg and the gain_fade_envelope RTL.
module tb;

  localparam int unsigned CycleLimit = 600_000;
  localparam int unsigned DrainCycles = 100;

  // One predicted result.
  typedef struct {
    bit        level_valid;
    bit [14:0] out_level;
    bit        fade_active;
    bit        fade_done;
  } level_result_t;

  // Tracks the fade state, predicts each result and checks the block against it.
  class fade_level_tracker;
    bit [6:0]          scale_pct;
    bit [14:0]         last_q78;
    bit [6:0]          logical_lvl;
    bit [14:0]         from_q78;
    bit [6:0]          target_lvl;
    bit [31:0]         start_ms;
    bit [15:0]         length_ms;
    gfe_pkg::curve_e   shape;
    bit                running;
    level_result_t     pending_levels[$];
    int unsigned       errors;

    function new();
      scale_pct   = gfe_pkg::ScaleReset;
      last_q78    = '0;
      logical_lvl = '0;
      from_q78    = '0;
      target_lvl  = '0;
      start_ms    = '0;
      length_ms   = '0;
      shape       = gfe_pkg::CurveNone;
      running     = 1'b0;
      errors      = 0;
    endfunction

    // A written scale above the maximum is held at the maximum.
    function void write_scale(bit [6:0] pct);
      scale_pct = (pct > gfe_pkg::ScaleMax) ? gfe_pkg::ScaleMax : pct;
    endfunction

    function bit [14:0] scaled(bit [14:0] q78);
      bit [31:0] prod;
      prod = 32'(q78) * 32'(scale_pct);
      return 15'(prod / 32'd100);
    endfunction

    // Apply one accepted request to the state and queue its result.
    function void note_request(gfe_pkg::opcode_e op, bit [31:0] now, bit [6:0] tgt,
                               bit [15:0] fms, gfe_pkg::curve_e crv);
      level_result_t res;
      bit [31:0]     elapsed;
      bit [31:0]     frac;
      bit [31:0]     p;
      bit [31:0]     t_q;
      bit [31:0]     f_q;
      bit [31:0]     low;
      bit [31:0]     span;
      bit [63:0]     v;
      bit            have;
      bit            rising;
      res = '{level_valid: 1'b0, out_level: '0, fade_active: 1'b0, fade_done: 1'b0};
      case (op)
        gfe_pkg::OpSetLevel: begin
          logical_lvl = tgt;
          last_q78 = scaled({tgt, 8'h00});
          running = 1'b0;
          shape = gfe_pkg::CurveNone;
          start_ms = '0;
          res.level_valid = 1'b1;
        end
        gfe_pkg::OpStartFade: begin
          start_ms = now;
          shape = crv;
          length_ms = fms;
          from_q78 = last_q78;
          target_lvl = tgt;
          logical_lvl = tgt;
          running = 1'b1;
        end
        gfe_pkg::OpTick: begin
          if (running) begin
            elapsed = now - start_ms;
            if (length_ms == 0 || elapsed >= 32'(length_ms)) begin
              // The fade is complete: the target is applied and the fade ends.
              logical_lvl = target_lvl;
              last_q78 = scaled({target_lvl, 8'h00});
              running = 1'b0;
              shape = gfe_pkg::CurveNone;
              start_ms = '0;
              res.level_valid = 1'b1;
              res.fade_done = 1'b1;
            end else begin
              frac = 32'((64'(elapsed) << 16) / 64'(length_ms));
              t_q = 32'(target_lvl) << 8;
              f_q = 32'(from_q78);
              rising = (t_q >= f_q);
              p = rising ? 32'd65536 - frac : frac;
              v = '0;
              have = 1'b0;
              case (shape)
                gfe_pkg::CurveLinear: begin
                  v = 64'd65536 - 64'(p);
                  have = 1'b1;
                end
                gfe_pkg::CurveEqualPower: begin
                  v = 64'd65536 - ((64'(p) * 64'(p)) >> 16);
                  have = 1'b1;
                end
                gfe_pkg::CurveExp: begin
                  // An exponential with p of zero is infinite and is not applied.
                  if (p != 0) begin
                    v = 64'(gfe_pkg::ExpK) / 64'(p);
                    have = 1'b1;
                  end
                end
                default: ;
              endcase
              if (have && v <= 64'd65536) begin
                low = rising ? f_q : t_q;
                span = rising ? t_q - f_q : f_q - t_q;
                last_q78 = scaled(15'(low + 32'((64'(span) * v) >> 16)));
                res.level_valid = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      res.out_level = last_q78;
      res.fade_active = running;
      pending_levels.push_back(res);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(bit lv, bit [14:0] lvl, bit act, bit dn);
      level_result_t exp_res;
      if (pending_levels.size() == 0) begin
        $error("result with no request outstanding: level_valid %0d out_level %0d",
               lv, lvl);
        errors++;
        return;
      end
      exp_res = pending_levels.pop_front();
      if (lv != exp_res.level_valid) begin
        $error("level_valid: expected %0d, got %0d", exp_res.level_valid, lv);
        errors++;
      end
      if (lvl != exp_res.out_level) begin
        $error("out_level: expected %0d, got %0d", exp_res.out_level, lvl);
        errors++;
      end
      if (act != exp_res.fade_active) begin
        $error("fade_active: expected %0d, got %0d", exp_res.fade_active, act);
        errors++;
      end
      if (dn != exp_res.fade_done) begin
        $error("fade_done: expected %0d, got %0d", exp_res.fade_done, dn);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = gfe_pkg::OpNop;
  logic [31:0] now_ms_i = '0;
  logic [6:0]  target_level_i = '0;
  logic [15:0] fade_ms_i = '0;
  logic [1:0]  curve_i = gfe_pkg::CurveNone;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        level_valid_o;
  logic [14:0] out_level_o;
  logic        fade_active_o;
  logic        fade_done_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fade_level_tracker levels;
  int unsigned       level_requests = 0;
  int unsigned       burst_left = 0;
  int unsigned       cycles = 0;
  int unsigned       ready_mode = 0;
  int unsigned       ready_left = 0;

  gain_fade_envelope DUT (.*);

  always #5 clk_i = ~clk_i;

  // Give up if the run hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result receiver: stalls on a pattern that changes mode every so often.
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(16, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ((ready_left % 8) < 5);
    endcase
  end

  // Check every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      levels.check_result(level_valid_o, out_level_o, fade_active_o, fade_done_o);
    end
  end

  // Send one request; the sender works in bursts with random gaps between them.
  task automatic send_request(input gfe_pkg::opcode_e op, input logic [31:0] now,
                              input logic [6:0] tgt, input logic [15:0] fms,
                              input gfe_pkg::curve_e crv);
    int unsigned gap;
    if (op == gfe_pkg::OpStartFade || op == gfe_pkg::OpSetLevel ||
        (op == gfe_pkg::OpTick && levels.running)) begin
      level_requests++;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    opcode_i = op;
    now_ms_i = now;
    target_level_i = tgt;
    fade_ms_i = fms;
    curve_i = crv;
    do @(posedge clk_i); while (!in_ready_o);
    levels.note_request(op, now, tgt, fms, crv);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Write the volume scale once every outstanding result has arrived.
  task automatic write_scale(input logic [6:0] pct);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (levels.pending_levels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {gfe_pkg::RegVolumeScale, 2'b00};
    pwdata = 32'(pct);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    levels.write_scale(pct);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Field extremes, every opcode and curve, and the special cases.
  task automatic directed_requests();
    // Idle tick with its fields at zero, and no-op with every field at its top.
    send_request(gfe_pkg::OpTick, 32'h0, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpNop, 32'hFFFF_FFFF, 7'd127, 16'hFFFF, gfe_pkg::CurveNone);
    send_request(gfe_pkg::OpSetLevel, 32'h0, 7'd127, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpSetLevel, 32'h0, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    // Rising linear fade across the time wrap, ending in completion.
    send_request(gfe_pkg::OpStartFade, 32'hFFFF_FF00, 7'd127, 16'd1000,
                 gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpTick, 32'hFFFF_FFFA, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpTick, 32'h0000_0100, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpTick, 32'h0000_0300, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    // Falling equal-power fade.
    send_request(gfe_pkg::OpStartFade, 32'd1000, 7'd0, 16'd400, gfe_pkg::CurveEqualPower);
    send_request(gfe_pkg::OpTick, 32'd1100, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpTick, 32'd1300, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpTick, 32'd1400, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    // Falling exponential: the first tick has p of zero and applies nothing.
    send_request(gfe_pkg::OpSetLevel, 32'h0, 7'd64, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpStartFade, 32'd5000, 7'd0, 16'd100, gfe_pkg::CurveExp);
    send_request(gfe_pkg::OpTick, 32'd5000, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpTick, 32'd5050, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpTick, 32'd5099, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpTick, 32'd5100, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    // A zero-length fade completes on its first tick.
    send_request(gfe_pkg::OpStartFade, 32'h0, 7'd127, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpTick, 32'hFFFF_FFFF, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    // No curve over the longest fade: silent until it completes.
    send_request(gfe_pkg::OpSetLevel, 32'h0, 7'd10, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpStartFade, 32'd7, 7'd120, 16'hFFFF, gfe_pkg::CurveNone);
    send_request(gfe_pkg::OpTick, 32'd30000, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpTick, 32'd65542, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    // Rising exponential, then a set level that cancels it.
    send_request(gfe_pkg::OpSetLevel, 32'h0, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpStartFade, 32'h0, 7'd100, 16'd1000, gfe_pkg::CurveExp);
    send_request(gfe_pkg::OpTick, 32'd10, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpTick, 32'd999, 7'd0, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpSetLevel, 32'h0, 7'd50, 16'd0, gfe_pkg::CurveLinear);
    send_request(gfe_pkg::OpTick, 32'd2000, 7'd0, 16'd0, gfe_pkg::CurveLinear);
  endtask

  // One fade with random content: optional set level, start, then rising ticks.
  task automatic fade_sequence();
    logic [31:0] t0;
    logic [31:0] off;
    logic [15:0] len;
    int unsigned sel;
    int unsigned n_ticks;
    sel = $urandom_range(0, 9);
    if (sel < 3) t0 = $urandom;
    else if (sel < 4) t0 = 32'hFFFF_FFFF - $urandom_range(0, 400);
    else t0 = $urandom_range(0, 100000);
    case ($urandom_range(0, 9))
      0: len = 16'd0;
      1: len = 16'($urandom);
      2: len = 16'hFFFF;
      default: len = 16'($urandom_range(1, 400));
    endcase
    if ($urandom_range(0, 2) == 0) begin
      send_request(gfe_pkg::OpSetLevel, $urandom, 7'($urandom_range(0, 127)), 16'($urandom),
                   gfe_pkg::curve_e'($urandom_range(0, 3)));
    end
    send_request(gfe_pkg::OpStartFade, t0, 7'($urandom_range(0, 127)), len,
                 gfe_pkg::curve_e'($urandom_range(0, 3)));
    n_ticks = $urandom_range(1, 8);
    off = '0;
    repeat (n_ticks) begin
      off = off + $urandom_range(0, 32'(len) / 4 + 2);
      case ($urandom_range(0, 19))
        0: send_request(gfe_pkg::OpTick, $urandom, 7'($urandom), 16'($urandom),
                        gfe_pkg::curve_e'($urandom_range(0, 3)));
        1: send_request(gfe_pkg::OpSetLevel, $urandom, 7'($urandom), 16'($urandom),
                        gfe_pkg::curve_e'($urandom_range(0, 3)));
        2: send_request(gfe_pkg::OpStartFade, t0 + off, 7'($urandom), len,
                        gfe_pkg::curve_e'($urandom_range(0, 3)));
        default: send_request(gfe_pkg::OpTick, t0 + off, 7'($urandom), 16'($urandom),
                              gfe_pkg::curve_e'($urandom_range(0, 3)));
      endcase
    end
    if ($urandom_range(0, 1) == 0) begin
      send_request(gfe_pkg::OpTick, t0 + 32'(len) + $urandom_range(0, 5), 7'($urandom),
                   16'($urandom), gfe_pkg::curve_e'($urandom_range(0, 3)));
    end
  endtask

  // Random stimulus until the given number of effective requests has gone out.
  task automatic random_requests(input int unsigned n);
    int unsigned goal;
    goal = level_requests + n;
    while (level_requests < goal) begin
      if ($urandom_range(0, 9) < 8) begin
        fade_sequence();
      end else begin
        send_request(gfe_pkg::opcode_e'($urandom_range(0, 3)), $urandom, 7'($urandom),
                     16'($urandom), gfe_pkg::curve_e'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    levels = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A write above the maximum is held at full scale.
    write_scale(7'd127);
    directed_requests();
    write_scale(7'd0);
    random_requests(40);
    write_scale(7'd1);
    random_requests(60);
    write_scale(7'd100);
    random_requests(150);
    write_scale(7'($urandom_range(2, 99)));
    random_requests(150);
    write_scale(7'($urandom_range(101, 127)));
    random_requests(100);

    // Let every outstanding result drain, then allow for any stray ones.
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (levels.pending_levels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (levels.errors == 0 && levels.pending_levels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
